// ===== rtl/core/gdd_pkg.sv =====
// Shared widths, constants and month table for the Gregorian date difference block.
// No dependencies; imported by gdd_div100, gregorian_date_difference, gdd_span_checker and tb.
`timescale 1ns / 1ps
`default_nettype none

package gdd_pkg;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int COUNT_W  = 23;
    localparam int DOY_W    = 9;
    // Internal signed width for the day sum before saturation
    localparam int SUM_W    = 25;
    // Quotient of a 14-bit year by 100
    localparam int Q_W      = 8;

    localparam int DEFAULT_MAX_YEAR = 9999;

    // floor(n / 100) = (n * 5243) >> 19, exact for n < 2^14
    localparam int RECIP       = 5243;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;

    localparam int COUNT_MAX = 4194303;
    localparam int COUNT_MIN = -4194304;

    // Days in the months that precede the given month in a common year;
    // months above twelve count as 31 days each.
    function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] month);
        logic [DOY_W-1:0] days;
        begin
            case (month)
                4'd0:    days = 9'd0;
                4'd1:    days = 9'd0;
                4'd2:    days = 9'd31;
                4'd3:    days = 9'd59;
                4'd4:    days = 9'd90;
                4'd5:    days = 9'd120;
                4'd6:    days = 9'd151;
                4'd7:    days = 9'd181;
                4'd8:    days = 9'd212;
                4'd9:    days = 9'd243;
                4'd10:   days = 9'd273;
                4'd11:   days = 9'd304;
                4'd12:   days = 9'd334;
                4'd13:   days = 9'd365;
                4'd14:   days = 9'd396;
                default: days = 9'd427;
            endcase
            return days;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gdd_div100.sv =====
// Shared divide-by-100 unit: reciprocal multiply with a registered quotient.
// Depends on gdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gdd_div100 (
    input  wire logic                       aclk,
    input  wire logic [gdd_pkg::YEAR_W-1:0] op_i,
    output logic      [gdd_pkg::Q_W-1:0]    quot_o
);
    import gdd_pkg::*;

    logic [YEAR_W+RECIP_W-1:0] prod;
    logic [Q_W-1:0]            quot_reg;

    assign prod = {{RECIP_W{1'b0}}, op_i} * (YEAR_W+RECIP_W)'(RECIP);

    always_ff @(posedge aclk) begin
        quot_reg <= prod[RECIP_SHIFT +: Q_W];
    end

    assign quot_o = quot_reg;

endmodule

`default_nettype wire

// ===== rtl/core/gregorian_date_difference.sv =====
// Top level of the Gregorian date difference block: sequencer and day arithmetic.
// Depends on gdd_pkg and gdd_div100.
`timescale 1ns / 1ps
`default_nettype none

// Counts the days from a start date to an end date under Gregorian leap rules.
// One request at a time: s_tready is high only while the block is idle. A word
// accepted on the slave side gives its result on m_tvalid after the divide,
// leap and sum steps; after the result is taken the block returns to idle
// before it accepts again. The single divide-by-100 unit runs three passes
// (start year, end year, year before the end year), followed by a step for
// leap flags and day-of-year and a step for the final sum and saturation. An
// end year before the start year gives a count of 0 with the error flag in
// m_tuser.
module gregorian_date_difference #(
    parameter int MAX_YEAR = gdd_pkg::DEFAULT_MAX_YEAR
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [4:0] start_day, [8:5] start_month, [22:9] start_year,
    // [27:23] end_day, [31:28] end_month, [45:32] end_year, [47:46] zero
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [22:0] day_count (signed), [23] zero
    output logic      [23:0] m_tdata,
    // [0] order_error
    output logic             m_tuser
);
    import gdd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_CALC = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic [1:0] STEP_Y1   = 2'd0;
    localparam logic [1:0] STEP_Y2   = 2'd1;
    localparam logic [1:0] STEP_YE   = 2'd2;
    localparam logic [1:0] STEP_LAST = 2'd3;

    logic [2:0] state_reg, state_next;
    logic [1:0] step_reg, step_next;

    logic [DAY_W-1:0]   d1_reg, d2_reg;
    logic [MONTH_W-1:0] m1_reg, m2_reg;
    logic [YEAR_W-1:0]  y1_reg, y2_reg;
    logic [Q_W-1:0]     q_reg [3];

    logic                leap1_reg;
    logic                after_reg, same_reg;
    logic [DOY_W-1:0]    doy1_reg, doy2_reg;
    logic signed [14:0]  leaps_reg;

    logic [COUNT_W-1:0] count_reg;
    logic               err_reg;

    logic               s_accept, m_accept;
    logic [YEAR_W-1:0]  in_y1, in_y2;
    logic [YEAR_W-1:0]  div_op;
    logic [Q_W-1:0]     div_q;
    logic [1:0]         q_idx;

    function automatic logic [YEAR_W-1:0] clamp_year(input logic [YEAR_W-1:0] y);
        begin
            if (int'(y) > MAX_YEAR) begin
                return YEAR_W'(MAX_YEAR);
            end
            return y;
        end
    endfunction

    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {1'b0, count_reg};
    assign m_tuser  = err_reg;

    assign in_y1 = clamp_year(s_tdata[22:9]);
    assign in_y2 = clamp_year(s_tdata[45:32]);

    always_comb begin
        case (step_reg)
            STEP_Y1: div_op = y1_reg;
            STEP_Y2: div_op = y2_reg;
            STEP_YE: div_op = y2_reg - YEAR_W'(1);
            default: div_op = y2_reg - YEAR_W'(1);
        endcase
    end

    assign q_idx = step_reg - 2'd1;

    gdd_div100 u_div100 (
        .aclk   (aclk),
        .op_i   (div_op),
        .quot_o (div_q)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_DIV;
                    step_next  = STEP_Y1;
                end
            end
            ST_DIV: begin
                step_next = step_reg + 2'd1;
                if (step_reg == STEP_LAST) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: state_next = ST_SUM;
            ST_SUM:  state_next = ST_OUT;
            ST_OUT: begin
                if (m_accept) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_Y1;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Capture the input word
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            d1_reg <= s_tdata[4:0];
            m1_reg <= s_tdata[8:5];
            y1_reg <= in_y1;
            d2_reg <= s_tdata[27:23];
            m2_reg <= s_tdata[31:28];
            y2_reg <= in_y2;
        end
    end

    // Quotient of the pass issued in the previous cycle
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIV && step_reg != STEP_Y1) begin
            q_reg[q_idx] <= div_q;
        end
    end

    // Leap flags, day of year and leap years strictly between the two years
    logic [YEAR_W-1:0]  r1, r2, ye;
    logic               leap1, leap2;
    logic [DOY_W-1:0]   doy1, doy2;
    logic [12:0]        lu_end, lu_start;

    always_comb begin
        r1 = y1_reg - YEAR_W'(q_reg[0]) * YEAR_W'(100);
        r2 = y2_reg - YEAR_W'(q_reg[1]) * YEAR_W'(100);
        leap1 = (y1_reg[1:0] == 2'd0) && ((r1 != '0) || (q_reg[0][1:0] == 2'd0));
        leap2 = (y2_reg[1:0] == 2'd0) && ((r2 != '0) || (q_reg[1][1:0] == 2'd0));
        doy1 = cum_days(m1_reg) + DOY_W'(d1_reg)
             + DOY_W'((m1_reg > MONTH_W'(2)) && leap1);
        doy2 = cum_days(m2_reg) + DOY_W'(d2_reg)
             + DOY_W'((m2_reg > MONTH_W'(2)) && leap2);
        ye = y2_reg - YEAR_W'(1);
        // leaps in 1..n = n/4 - n/100 + n/400, with n/400 = (n/100)/4
        lu_end   = 13'(ye >> 2) - 13'(q_reg[2]) + 13'(q_reg[2] >> 2);
        lu_start = 13'(y1_reg >> 2) - 13'(q_reg[0]) + 13'(q_reg[0] >> 2);
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CALC) begin
            leap1_reg <= leap1;
            doy1_reg  <= doy1;
            doy2_reg  <= doy2;
            leaps_reg <= $signed({2'b00, lu_end}) - $signed({2'b00, lu_start});
            after_reg <= (y2_reg > y1_reg);
            same_reg  <= (y2_reg == y1_reg);
        end
    end

    // Final sum and saturation
    logic [YEAR_W-1:0]        between;
    logic signed [SUM_W-1:0]  sum;

    always_comb begin
        between = y2_reg - y1_reg - YEAR_W'(1);
        if (same_reg) begin
            sum = $signed(SUM_W'(doy2_reg)) - $signed(SUM_W'(doy1_reg));
        end else if (after_reg) begin
            sum = $signed(SUM_W'(leap1_reg ? 366 : 365)) - $signed(SUM_W'(doy1_reg))
                + $signed(SUM_W'(between) * SUM_W'(365))
                + SUM_W'(leaps_reg)
                + $signed(SUM_W'(doy2_reg));
        end else begin
            sum = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SUM) begin
            err_reg <= !same_reg && !after_reg;
            if (sum > $signed(SUM_W'(COUNT_MAX))) begin
                count_reg <= COUNT_W'(COUNT_MAX);
            end else if (sum < $signed(SUM_W'(COUNT_MIN))) begin
                count_reg <= COUNT_W'(COUNT_MIN);
            end else begin
                count_reg <= sum[COUNT_W-1:0];
            end
        end
    end

`ifndef SYNTHESIS
    a_out_blocks_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("slave side ready while a result is pending");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("order error with nonzero day count");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
        else $error("block not busy after accepting a word");

    a_sum_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM) |=> m_tvalid)
        else $error("result not presented after the sum step");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/gdd_span_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for gregorian_date_difference: predicts the day count of every
// accepted request word and compares it with the result word. Uses gdd_pkg.
module gdd_span_checker #(
    parameter int MAX_YEAR = gdd_pkg::DEFAULT_MAX_YEAR
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // [4:0] start_day, [8:5] start_month, [22:9] start_year,
    // [27:23] end_day, [31:28] end_month, [45:32] end_year, [47:46] zero
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [22:0] day_count (signed), [23] zero
    input  logic [23:0] m_tdata,
    // [0] order_error
    input  logic        m_tuser,
    output int          mismatches,
    output int          spans_due
);
    import gdd_pkg::*;

    typedef struct packed {
        logic signed [COUNT_W-1:0] day_count;
        logic                      order_error;
    } span_t;

    span_t span_queue[$];

    function automatic bit leap_year(int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    // Leap years in 1..n
    function automatic int leaps_through(int unsigned n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    function automatic int day_in_year(logic [DAY_W-1:0] day, logic [MONTH_W-1:0] month,
                                       int unsigned year);
        int total;
        total = day;
        for (int m = 1; m < month; m++) begin
            if (m == 2)
                total += leap_year(year) ? 29 : 28;
            else if (m == 4 || m == 6 || m == 9 || m == 11)
                total += 30;
            else
                total += 31;
        end
        return total;
    endfunction

    function automatic int unsigned sat_year(logic [YEAR_W-1:0] y);
        return (y > MAX_YEAR) ? MAX_YEAR : y;
    endfunction

    function automatic span_t span_of(logic [47:0] w);
        int unsigned y1;
        int unsigned y2;
        longint doy1;
        longint doy2;
        longint rest;
        longint between;
        longint leaps;
        longint count;
        span_t r;
        y1 = sat_year(w[22:9]);
        y2 = sat_year(w[45:32]);
        doy1 = day_in_year(w[4:0], w[8:5], y1);
        doy2 = day_in_year(w[27:23], w[31:28], y2);
        count = 0;
        r.order_error = 1'b0;
        if (y2 < y1) begin
            r.order_error = 1'b1;
        end else if (y1 == y2) begin
            count = doy2 - doy1;
        end else begin
            rest = (leap_year(y1) ? 366 : 365) - doy1;
            between = longint'(y2 - y1) - 1;
            leaps = longint'(leaps_through(y2 - 1)) - longint'(leaps_through(y1));
            count = rest + between * 365 + leaps + doy2;
        end
        if (count > COUNT_MAX)
            count = COUNT_MAX;
        if (count < COUNT_MIN)
            count = COUNT_MIN;
        r.day_count = count[COUNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    initial begin
        mismatches = 0;
        spans_due = 0;
    end

    always @(posedge aclk) begin
        span_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (span_queue.size() == 0) begin
                    report_mismatch("result word with nothing pending",
                                    $signed(m_tdata[COUNT_W-1:0]), 0);
                end else begin
                    want = span_queue.pop_front();
                    if (m_tdata[COUNT_W-1:0] !== want.day_count)
                        report_mismatch("day_count", $signed(m_tdata[COUNT_W-1:0]),
                                        longint'(want.day_count));
                    if (m_tuser !== want.order_error)
                        report_mismatch("order_error", m_tuser, want.order_error);
                end
            end
            if (s_tvalid && s_tready)
                span_queue.push_back(span_of(s_tdata));
            spans_due = span_queue.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for gregorian_date_difference: drives request words and result
// backpressure, and gives the verdict. Needs gdd_pkg and gdd_span_checker.
module tb;
    import gdd_pkg::*;

    localparam int RANDOM_WORDS   = 1650;
    localparam int BACKLOG_CYCLES = 400;
    // Longest quiet stretch: the backlog hold plus a long run of random stalls
    localparam int STALL_LIMIT    = 3000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [47:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;
    logic        m_tuser;

    logic        no_idle      = 1'b0;
    logic        backlog_req  = 1'b0;
    logic        backlog_done = 1'b0;
    int          mismatches;
    int          spans_due;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    gregorian_date_difference i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    gdd_span_checker i_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .spans_due  (spans_due)
    );

    function automatic logic [47:0] pack_dates(
        logic [DAY_W-1:0] d1, logic [MONTH_W-1:0] m1, logic [YEAR_W-1:0] y1,
        logic [DAY_W-1:0] d2, logic [MONTH_W-1:0] m2, logic [YEAR_W-1:0] y2);
        return {2'b00, y2, m2, d2, y1, m1, d1};
    endfunction

    // Mostly plausible dates with related years; the rest raw noise
    function automatic logic [47:0] random_dates();
        logic [63:0] raw;
        int y1;
        int y2;
        if ($urandom_range(0, 9) == 0) begin
            raw = {$urandom, $urandom};
            return {2'b00, raw[45:0]};
        end
        if ($urandom_range(0, 3) == 0)
            y1 = 100 * $urandom_range(0, 99) + $urandom_range(0, 4);
        else
            y1 = $urandom_range(1, 9999);
        case ($urandom_range(0, 3))
            0: y2 = y1;
            1: y2 = y1 + $urandom_range(1, 5);
            2: y2 = $urandom_range(1, 9999);
            default: y2 = (y1 > 3) ? y1 - $urandom_range(1, 3) : y1;
        endcase
        return pack_dates(DAY_W'($urandom_range(1, 31)), MONTH_W'($urandom_range(1, 12)),
                          YEAR_W'(y1),
                          DAY_W'($urandom_range(1, 31)), MONTH_W'($urandom_range(1, 12)),
                          YEAR_W'(y2));
    endfunction

    task automatic send_word(logic [47:0] w);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 33) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Hold the request side until every pending result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (spans_due != 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(pack_dates(15, 6, 2024, 15, 6, 2024));
        send_word(pack_dates(1, 1, 1, 31, 12, 9999));
        send_word(pack_dates(31, 12, 9999, 1, 1, 1));
        send_word(pack_dates(31, 12, 2023, 1, 1, 2023));
        send_word(pack_dates(28, 2, 2000, 1, 3, 2000));
        send_word(pack_dates(28, 2, 1900, 1, 3, 1900));
        send_word(pack_dates(1, 3, 2003, 1, 3, 2004));
        send_word(pack_dates(31, 12, 1899, 1, 1, 2401));
        send_word(pack_dates(1, 1, 399, 1, 1, 401));
        send_word(pack_dates(29, 2, 2024, 1, 1, 2025));
        // day zero, month zero, months past December
        send_word(pack_dates(0, 1, 2020, 0, 3, 2020));
        send_word(pack_dates(10, 0, 2020, 10, 0, 2021));
        send_word(pack_dates(31, 15, 2024, 31, 13, 2025));
        // year zero counts as leap
        send_word(pack_dates(1, 3, 0, 1, 3, 1));
        // years past the maximum saturate
        send_word(pack_dates(1, 1, 9998, 1, 1, 10000));
        send_word(pack_dates(1, 1, 16383, 1, 1, 9999));
        send_word(pack_dates(1, 1, 16383, 1, 1, 9998));
        send_word(pack_dates(0, 0, 0, 0, 0, 0));
        send_word(pack_dates(31, 15, 16383, 31, 15, 16383));
        send_word(pack_dates(31, 15, 0, 0, 0, 9999));
        send_word(pack_dates(0, 0, 0, 31, 15, 16383));
        send_word(pack_dates(31, 15, 2000, 0, 0, 2000));

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            no_idle = (i >= 700 && i < 1000);
            if (i == 1100)
                backlog_req = 1'b1;
            if (i == 400 || i == 1300)
                drain_results();
            send_word(random_dates());
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("gregorian_date_difference verification clean");
        else
            $display("gregorian_date_difference verification failed");
        $finish;
    end

    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (backlog_req && !backlog_done) begin
                // hold off results so the block backs up its request side
                backlog_done = 1'b1;
                m_tready <= 1'b0;
                repeat (BACKLOG_CYCLES) @(posedge aclk);
            end
            m_tready <= no_idle || ($urandom_range(0, 99) >= 33);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        wait (aresetn);
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("gregorian_date_difference verification failed");
        $finish;
    end

endmodule
